FILE: hdl/tpq_pkg.sv
// tpq_pkg: shared types and constants for the two-level priority queue
// holds operation, source and status codes, config register indexes and default sizes
// no dependencies
package tpq_pkg;

    localparam int DEFAULT_NORMAL_DEPTH   = 16;
    localparam int DEFAULT_PRIORITY_DEPTH = 16;
    localparam int DEFAULT_DATA_WIDTH     = 32;

    // configuration register file
    localparam int CFG_WIDTH       = 5;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_WIDTH-1:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_NORMAL_CAPACITY   = 1'b0,
        REG_PRIORITY_CAPACITY = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_WRITE_NORMAL   = 2'd0,
        OP_WRITE_PRIORITY = 2'd1,
        OP_POST_MAILBOX   = 2'd2,
        OP_READ           = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SRC_NONE     = 2'd0,
        SRC_MAILBOX  = 2'd1,
        SRC_PRIORITY = 2'd2,
        SRC_NORMAL   = 2'd3
    } source_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_REFUSED = 2'd1,
        STAT_EMPTY   = 2'd2
    } status_t;

endpackage

FILE: hdl/two_level_priority_queue_with_mailbox_core.sv
// two_level_priority_queue_with_mailbox_core: strict priority message queue
// normal ring fifo, priority ring fifo and a one-word mailbox; uses tpq_pkg
// fifo storage sits in two synchronous single-port-style memories
//
// usage
//   command channel: operation and item_value are taken at a rising edge with
//   start high and busy low. busy is never raised: one command per cycle is
//   taken without a gap, since each command touches at most one memory entry
//   and the pointer/count registers.
//   result channel: exactly one result word per command, shown for one cycle
//   with done high, in the cycle right after the command edge. the fifo read
//   data comes straight out of the memory read register. the receiver cannot
//   stall; results are lost if not sampled in their done cycle.
//   read priority: mailbox first, then priority fifo, then normal fifo.
//   writes to a full fifo or a post to an occupied mailbox are refused.
//   config: cfg_write with cfg_index 0 sets normal capacity, 1 priority
//   capacity; capacity above the fifo depth acts as the depth. write only
//   while idle.
//   reset: pointers, counts, mailbox and capacities (16) cleared at once; the
//   fifo memories are not cleared, an entry is only read after it is written.
module two_level_priority_queue_with_mailbox_core #(
    parameter int NORMAL_DEPTH   = tpq_pkg::DEFAULT_NORMAL_DEPTH,
    parameter int PRIORITY_DEPTH = tpq_pkg::DEFAULT_PRIORITY_DEPTH,
    parameter int DATA_WIDTH     = tpq_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          operation,
    input  logic [DATA_WIDTH-1:0]               item_value,
    // config write port
    input  logic                                cfg_write,
    input  logic [tpq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tpq_pkg::CFG_WIDTH-1:0]       cfg_data,
    // result channel
    output logic                                done,
    output logic [DATA_WIDTH-1:0]               read_value,
    output logic [1:0]                          source,
    output logic [1:0]                          status,
    output logic                                normal_full,
    output logic                                priority_full,
    output logic                                normal_empty,
    output logic                                priority_empty,
    output logic                                mailbox_full
);

    localparam int NPW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int PPW = (PRIORITY_DEPTH > 1) ? $clog2(PRIORITY_DEPTH) : 1;
    localparam int NCW = $clog2(NORMAL_DEPTH + 1);
    localparam int PCW = $clog2(PRIORITY_DEPTH + 1);
    localparam int CW  = tpq_pkg::CFG_WIDTH;

    localparam logic [NPW-1:0] N_LAST = NPW'(NORMAL_DEPTH - 1);
    localparam logic [PPW-1:0] P_LAST = PPW'(PRIORITY_DEPTH - 1);
    localparam logic [NCW-1:0] N_DEPTH_C = NCW'(NORMAL_DEPTH);
    localparam logic [PCW-1:0] P_DEPTH_C = PCW'(PRIORITY_DEPTH);

    // fifo memories, no reset
    logic [DATA_WIDTH-1:0] normal_mem   [NORMAL_DEPTH];
    logic [DATA_WIDTH-1:0] priority_mem [PRIORITY_DEPTH];

    // config registers
    logic [CW-1:0] normal_cap_reg;
    logic [CW-1:0] priority_cap_reg;

    // queue control state
    logic [NPW-1:0] normal_head_reg, normal_head_next;
    logic [NPW-1:0] normal_tail_reg, normal_tail_next;
    logic [NCW-1:0] normal_count_reg, normal_count_next;
    logic [PPW-1:0] priority_head_reg, priority_head_next;
    logic [PPW-1:0] priority_tail_reg, priority_tail_next;
    logic [PCW-1:0] priority_count_reg, priority_count_next;
    logic [DATA_WIDTH-1:0] mailbox_value_reg, mailbox_value_next;
    logic                  mailbox_valid_reg, mailbox_valid_next;

    // result stage
    logic                  done_reg;
    tpq_pkg::source_t      source_reg, source_next;
    tpq_pkg::status_t      status_reg, status_next;
    logic                  normal_full_reg, priority_full_reg;
    logic                  normal_empty_reg, priority_empty_reg;
    logic [DATA_WIDTH-1:0] mbox_out_reg;
    logic [DATA_WIDTH-1:0] normal_rdata_reg;
    logic [DATA_WIDTH-1:0] priority_rdata_reg;

    logic            accept;
    tpq_pkg::op_t    op;
    logic            normal_at_cap, priority_at_cap;
    logic            normal_wr_en, priority_wr_en;
    logic            normal_rd_en, priority_rd_en;
    logic            normal_full_next, priority_full_next;

    assign busy   = 1'b0;   // every command is taken in the cycle it appears
    assign accept = start && !busy;
    assign op     = tpq_pkg::op_t'(operation);

    // full test against min(capacity, depth): count >= cap or count >= depth
    function automatic logic at_cap_n(input logic [NCW-1:0] cnt, input logic [CW-1:0] cap);
        logic ge_cap;
        if (NCW >= CW)
            ge_cap = cnt >= NCW'(cap);
        else
            ge_cap = CW'(cnt) >= cap;
        return ge_cap || (cnt >= N_DEPTH_C);
    endfunction

    function automatic logic at_cap_p(input logic [PCW-1:0] cnt, input logic [CW-1:0] cap);
        logic ge_cap;
        if (PCW >= CW)
            ge_cap = cnt >= PCW'(cap);
        else
            ge_cap = CW'(cnt) >= cap;
        return ge_cap || (cnt >= P_DEPTH_C);
    endfunction

    assign normal_at_cap   = at_cap_n(normal_count_reg, normal_cap_reg);
    assign priority_at_cap = at_cap_p(priority_count_reg, priority_cap_reg);

    // command decode and next control state
    always_comb
    begin
        normal_wr_en        = 1'b0;
        priority_wr_en      = 1'b0;
        normal_rd_en        = 1'b0;
        priority_rd_en      = 1'b0;
        normal_head_next    = normal_head_reg;
        normal_tail_next    = normal_tail_reg;
        normal_count_next   = normal_count_reg;
        priority_head_next  = priority_head_reg;
        priority_tail_next  = priority_tail_reg;
        priority_count_next = priority_count_reg;
        mailbox_value_next  = mailbox_value_reg;
        mailbox_valid_next  = mailbox_valid_reg;
        source_next         = tpq_pkg::SRC_NONE;
        status_next         = tpq_pkg::STAT_OK;
        if (accept)
        begin
            case (op)
                tpq_pkg::OP_WRITE_NORMAL:
                begin
                    if (normal_at_cap)
                        status_next = tpq_pkg::STAT_REFUSED;
                    else
                    begin
                        normal_wr_en      = 1'b1;
                        normal_tail_next  = (normal_tail_reg == N_LAST) ? '0
                                            : normal_tail_reg + 1'b1;
                        normal_count_next = normal_count_reg + 1'b1;
                    end
                end
                tpq_pkg::OP_WRITE_PRIORITY:
                begin
                    if (priority_at_cap)
                        status_next = tpq_pkg::STAT_REFUSED;
                    else
                    begin
                        priority_wr_en      = 1'b1;
                        priority_tail_next  = (priority_tail_reg == P_LAST) ? '0
                                              : priority_tail_reg + 1'b1;
                        priority_count_next = priority_count_reg + 1'b1;
                    end
                end
                tpq_pkg::OP_POST_MAILBOX:
                begin
                    if (mailbox_valid_reg)
                        status_next = tpq_pkg::STAT_REFUSED;
                    else
                    begin
                        mailbox_value_next = item_value;
                        mailbox_valid_next = 1'b1;
                    end
                end
                tpq_pkg::OP_READ:
                begin
                    if (mailbox_valid_reg)
                    begin
                        mailbox_valid_next = 1'b0;
                        source_next        = tpq_pkg::SRC_MAILBOX;
                    end
                    else if (priority_count_reg != '0)
                    begin
                        priority_rd_en      = 1'b1;
                        priority_head_next  = (priority_head_reg == P_LAST) ? '0
                                              : priority_head_reg + 1'b1;
                        priority_count_next = priority_count_reg - 1'b1;
                        source_next         = tpq_pkg::SRC_PRIORITY;
                    end
                    else if (normal_count_reg != '0)
                    begin
                        normal_rd_en      = 1'b1;
                        normal_head_next  = (normal_head_reg == N_LAST) ? '0
                                            : normal_head_reg + 1'b1;
                        normal_count_next = normal_count_reg - 1'b1;
                        source_next       = tpq_pkg::SRC_NORMAL;
                    end
                    else
                        status_next = tpq_pkg::STAT_EMPTY;
                end
                default:
                begin
                    status_next = tpq_pkg::STAT_OK;
                end
            endcase
        end
    end

    assign normal_full_next   = at_cap_n(normal_count_next, normal_cap_reg);
    assign priority_full_next = at_cap_p(priority_count_next, priority_cap_reg);

    // normal fifo memory: one write or one registered read per command
    always_ff @(posedge clk)
    begin
        if (normal_wr_en)
            normal_mem[normal_tail_reg] <= item_value;
        if (normal_rd_en)
            normal_rdata_reg <= normal_mem[normal_head_reg];
    end

    // priority fifo memory
    always_ff @(posedge clk)
    begin
        if (priority_wr_en)
            priority_mem[priority_tail_reg] <= item_value;
        if (priority_rd_en)
            priority_rdata_reg <= priority_mem[priority_head_reg];
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_cap_reg   <= tpq_pkg::CAPACITY_RESET;
            priority_cap_reg <= tpq_pkg::CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            case (tpq_pkg::cfg_reg_t'(cfg_index))
                tpq_pkg::REG_NORMAL_CAPACITY:   normal_cap_reg   <= cfg_data;
                tpq_pkg::REG_PRIORITY_CAPACITY: priority_cap_reg <= cfg_data;
                default:                        normal_cap_reg   <= normal_cap_reg;
            endcase
        end
    end

    // control state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_head_reg    <= '0;
            normal_tail_reg    <= '0;
            normal_count_reg   <= '0;
            priority_head_reg  <= '0;
            priority_tail_reg  <= '0;
            priority_count_reg <= '0;
            mailbox_value_reg  <= '0;
            mailbox_valid_reg  <= 1'b0;
            done_reg           <= 1'b0;
            source_reg         <= tpq_pkg::SRC_NONE;
            status_reg         <= tpq_pkg::STAT_OK;
            normal_full_reg    <= 1'b0;
            priority_full_reg  <= 1'b0;
            normal_empty_reg   <= 1'b1;
            priority_empty_reg <= 1'b1;
        end
        else
        begin
            normal_head_reg    <= normal_head_next;
            normal_tail_reg    <= normal_tail_next;
            normal_count_reg   <= normal_count_next;
            priority_head_reg  <= priority_head_next;
            priority_tail_reg  <= priority_tail_next;
            priority_count_reg <= priority_count_next;
            mailbox_value_reg  <= mailbox_value_next;
            mailbox_valid_reg  <= mailbox_valid_next;
            done_reg           <= accept;
            if (accept)
            begin
                source_reg         <= source_next;
                status_reg         <= status_next;
                normal_full_reg    <= normal_full_next;
                priority_full_reg  <= priority_full_next;
                normal_empty_reg   <= (normal_count_next == '0);
                priority_empty_reg <= (priority_count_next == '0);
            end
        end
    end

    // mailbox word handed out on a read, payload only
    always_ff @(posedge clk)
    begin
        if (accept)
            mbox_out_reg <= mailbox_value_reg;
    end

    // pick the word for the result from its source
    always_comb
    begin
        case (source_reg)
            tpq_pkg::SRC_MAILBOX:  read_value = mbox_out_reg;
            tpq_pkg::SRC_PRIORITY: read_value = priority_rdata_reg;
            tpq_pkg::SRC_NORMAL:   read_value = normal_rdata_reg;
            default:               read_value = '0;
        endcase
    end

    assign done           = done_reg;
    assign source         = source_reg;
    assign status         = status_reg;
    assign normal_full    = normal_full_reg;
    assign priority_full  = priority_full_reg;
    assign normal_empty   = normal_empty_reg;
    assign priority_empty = priority_empty_reg;
    assign mailbox_full   = mailbox_valid_reg;

    // checks
    a_one_result_per_command: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("command gave no result word");

    a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (normal_count_reg <= N_DEPTH_C) && (priority_count_reg <= P_DEPTH_C))
        else $error("fifo count beyond depth");

    a_empty_pointers_meet: assert property (@(posedge clk) disable iff (!rst_n)
        ((normal_count_reg == '0) |-> (normal_head_reg == normal_tail_reg)) and
        ((priority_count_reg == '0) |-> (priority_head_reg == priority_tail_reg)))
        else $error("empty fifo with pointers apart");

    a_source_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (source_reg != tpq_pkg::SRC_NONE)) |-> (status_reg == tpq_pkg::STAT_OK))
        else $error("word returned with a failing status");

    a_mailbox_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (source_reg == tpq_pkg::SRC_MAILBOX)) |-> !mailbox_valid_reg)
        else $error("mailbox still full after it was read");

endmodule
